// ===== hdl/afsk_pkg.sv =====
// afsk_pkg: register indexes, reset values and the sine table builder
// used by the afsk bit modulator. No dependencies.

package afsk_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SpbW = 7;

  localparam logic [CfgIdxW-1:0] REG_MARK_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SPACE_STEP = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SAMPLES_PER_BIT = 2'd2;

  localparam logic [CfgDataW-1:0] MARK_STEP_RST = 32'd372827022;
  localparam logic [CfgDataW-1:0] SPACE_STEP_RST = 32'd279620267;
  localparam logic [SpbW-1:0] SPB_RST = 7'd46;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [CfgDataW-1:0] step_t;

  // divides a series term by (2n)(2n+1)
  function automatic logic [63:0] term_div(input logic [63:0] term, input int n);
    logic [63:0] q;
    case (n)
      1: q = term / 64'd6;
      2: q = term / 64'd20;
      3: q = term / 64'd42;
      4: q = term / 64'd72;
      5: q = term / 64'd110;
      6: q = term / 64'd156;
      default: q = term / 64'd210;
    endcase
    return q;
  endfunction

  // quarter-wave entry k, taylor series in q30, scaled and saturated
  function automatic logic [31:0] sine_entry(input int unsigned k, input int addr_bits,
                                             input int sample_bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] full;
    logic [63:0] v;
    logic signed [63:0] sum;
    x = (64'(k) * HALF_PI_Q30) >> (addr_bits - 2);
    term = x;
    sum = signed'(x);
    full = 64'd1 << (sample_bits - 1);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term_div(term, n);
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (unsigned'(sum) * full + (64'd1 << 29)) >> 30;
    if (v > full - 64'd1) begin
      v = full - 64'd1;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hdl/afsk_bit_modulator_unit.sv =====
// afsk_bit_modulator_unit: frequency-shift keyed sine generator, one bit in,
// samples_per_bit pcm samples out. Depends on afsk_pkg.
//
//   port group  | direction | transaction
//   in_*        | in        | one message bit (in_bit_value)
//   out_*       | out       | one sine sample (out_sample) and end-of-bit flag (out_last)
//   cfg_*       | in        | register write, no handshake
//
// one sample per cycle while out_stall is low; a bit lasts samples_per_bit samples (clamped to
// 1..MAX_SAMPLES_PER_BIT), counted by a sample index that advances once per emitted sample.
// the next bit is taken in the cycle that emits the last sample of the current one.
// synchronous active-low reset restores the register reset values; no clearing pass.
// out_stall freezes the output register and the generator; in_stall is high while
// the current bit still has samples to emit.

module afsk_bit_modulator_unit #(
  parameter int PHASE_BITS = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int MAX_SAMPLES_PER_BIT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_bit_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [afsk_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [afsk_pkg::CfgDataW-1:0] cfg_wdata
);

  import afsk_pkg::*;

  localparam int QLEN = 1 << (TABLE_ADDR_BITS - 2);
  localparam int QI_W = TABLE_ADDR_BITS - 1;
  localparam int IDX_W = $clog2(MAX_SAMPLES_PER_BIT);
  localparam int MAG_W = SAMPLE_BITS - 1;

  // quarter-wave table
  logic [MAG_W-1:0] qtab [0:QLEN];

  for (genvar g = 0; g <= QLEN; g++) begin : g_tab
    localparam logic [31:0] ENT = sine_entry(g, TABLE_ADDR_BITS, SAMPLE_BITS);
    assign qtab[g] = ENT[MAG_W-1:0];
  end

  // configuration
  step_t           mark_step_r, mark_step_nxt;
  step_t           space_step_r, space_step_nxt;
  logic [SpbW-1:0] spb_r, spb_nxt;

  always_comb begin
    mark_step_nxt = mark_step_r;
    space_step_nxt = space_step_r;
    spb_nxt = spb_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MARK_STEP: mark_step_nxt = cfg_wdata;
        REG_SPACE_STEP: space_step_nxt = cfg_wdata;
        REG_SAMPLES_PER_BIT: spb_nxt = cfg_wdata[SpbW-1:0];
        default: ;
      endcase
    end
  end

  // generator
  logic                  busy_r, busy_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      lastidx_r, lastidx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  adv;
  logic                  is_last;
  logic                  in_acc;
  logic [SpbW-1:0]       spb_clamp;
  step_t                 step_sel;

  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-3:0] kq;
  logic [QI_W-1:0]            tab_idx;
  logic [SAMPLE_BITS-1:0]     mag_ext;
  logic [SAMPLE_BITS-1:0]     lut_sample;

  assign addr = phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign quad = addr[TABLE_ADDR_BITS-1 -: 2];
  assign kq = addr[TABLE_ADDR_BITS-3:0];
  assign tab_idx = quad[0] ? (QI_W'(QLEN) - {1'b0, kq}) : {1'b0, kq};
  assign mag_ext = {1'b0, qtab[tab_idx]};
  assign lut_sample = quad[1] ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;

  assign adv = busy_r && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == lastidx_r);
  assign in_stall = busy_r && !(adv && is_last);
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    if (spb_r == '0) begin
      spb_clamp = SpbW'(1);
    end else if (spb_r > SpbW'(MAX_SAMPLES_PER_BIT)) begin
      spb_clamp = SpbW'(MAX_SAMPLES_PER_BIT);
    end else begin
      spb_clamp = spb_r;
    end
  end

  assign step_sel = in_bit_value ? mark_step_r : space_step_r;

  always_comb begin
    busy_nxt = busy_r;
    phase_nxt = phase_r;
    step_nxt = step_r;
    idx_nxt = idx_r;
    lastidx_nxt = lastidx_r;
    if (adv) begin
      phase_nxt = phase_r + step_r;
      idx_nxt = idx_r + IDX_W'(1);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
      phase_nxt = '0;
      idx_nxt = '0;
      step_nxt = PHASE_BITS'(step_sel);
      lastidx_nxt = IDX_W'(spb_clamp - SpbW'(1));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_last_nxt = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_sample_nxt = lut_sample;
      out_last_nxt = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_step_r <= MARK_STEP_RST;
      space_step_r <= SPACE_STEP_RST;
      spb_r <= SPB_RST;
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mark_step_r <= mark_step_nxt;
      space_step_r <= space_step_nxt;
      spb_r <= spb_nxt;
      busy_r <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    step_r <= step_nxt;
    idx_r <= idx_nxt;
    lastidx_r <= lastidx_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sample = signed'(out_sample_r);
  assign out_last = out_last_r;

  // a new bit starts at phase zero with index zero
  a_bit_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> busy_r && idx_r == '0 && phase_r == '0)
    else $error("bit did not start at phase zero");

  // the first sample of every bit is zero
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && idx_r == '0 |-> lut_sample == '0)
    else $error("first sample of bit not zero");

  // sample index never passes the last index
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= lastidx_r)
    else $error("sample index past end of bit");

  // idle generator never holds off the input
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !in_stall)
    else $error("input stalled while generator idle");

endmodule
